// File: hw/rtl/tet_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tet_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int ID_BITS_DEF     = 16;

    localparam int ACTION_W = 2;
    localparam int KIND_W   = 2;
    localparam int IN_ID_W  = 16;
    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 5;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [TIME_W-1:0] SIGHT_TIMEOUT_RST    = 32'd120;
    localparam logic [TIME_W-1:0] HEARING_TIMEOUT_RST  = 32'd300;
    localparam logic [TIME_W-1:0] ATTACKED_TIMEOUT_RST = 32'd180;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SIGHT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEARING  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACKED = 2'd2;

    // Entry kinds; the fourth code is never stored.
    localparam logic [KIND_W-1:0] KIND_SIGHT    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HEARING  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ATTACKED = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED   = 2'd3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_REGISTER = 2'd0,
        ACT_TICK     = 2'd1,
        ACT_REMOVE   = 2'd2,
        ACT_NOP      = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_DONE = 2'd2
    } t_state;

    typedef struct packed {
        t_action             action;
        logic [KIND_W-1:0]   sense_kind;
        logic [IN_ID_W-1:0]  target_id;
        logic [TIME_W-1:0]   now;
    } t_req;

    typedef struct packed {
        logic                success;
        logic                table_full;
        logic [COUNT_W-1:0]  expired_count;
        logic [COUNT_W-1:0]  occupied;
    } t_rsp;

    // Result of comparing one stored entry against the request.
    typedef struct packed {
        logic id_eq;
        logic key_eq;
        logic aged;
    } t_cmp;

endpackage

`default_nettype wire

// File: hw/rtl/tet_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/tet_cmp.sv
`timescale 1ns / 1ps
`default_nettype none

module tet_cmp #(
    parameter int ID_BITS = tet_pkg::ID_BITS_DEF
) (
    input  wire logic [tet_pkg::KIND_W-1:0] i_ent_kind,
    input  wire logic [ID_BITS-1:0]         i_ent_id,
    input  wire logic [tet_pkg::TIME_W-1:0] i_ent_time,
    input  wire logic [tet_pkg::KIND_W-1:0] i_req_kind,
    input  wire logic [ID_BITS-1:0]         i_req_id,
    input  wire logic [tet_pkg::TIME_W-1:0] i_now,
    input  wire logic [tet_pkg::TIME_W-1:0] i_sight_to,
    input  wire logic [tet_pkg::TIME_W-1:0] i_hearing_to,
    input  wire logic [tet_pkg::TIME_W-1:0] i_attacked_to,
    output tet_pkg::t_cmp                   o_cmp
);

    logic [tet_pkg::TIME_W-1:0] age;
    logic [tet_pkg::TIME_W-1:0] limit;

    always_comb begin
        case (i_ent_kind)
            tet_pkg::KIND_SIGHT:   limit = i_sight_to;
            tet_pkg::KIND_HEARING: limit = i_hearing_to;
            default:               limit = i_attacked_to;
        endcase
        // Age wraps modulo 2^32, so an old entry still ages out across a time rollover.
        age          = i_now - i_ent_time;
        o_cmp.id_eq  = (i_ent_id == i_req_id);
        o_cmp.key_eq = (i_ent_id == i_req_id) && (i_ent_kind == i_req_kind);
        o_cmp.aged   = (age >= limit);
    end

endmodule

`default_nettype wire

// File: hw/rtl/timed_entry_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Table of MAX_ENTRIES timed entries keyed by kind and ID. Each request walks
// every entry through one compare unit, one entry per cycle out of the entry
// RAM. A request passes three states in order: S_IDLE accepts it, S_SCAN
// streams the RAM through the compare unit, and S_DONE writes back and loads
// the response, holding while an earlier response is still not taken. The
// response sits in an output register, so a new request is taken while an
// earlier response still waits. Valid bits live in flip-flops and are cleared
// by reset, so the table is usable right after reset.
module timed_entry_table #(
    parameter int MAX_ENTRIES = tet_pkg::MAX_ENTRIES_DEF,
    parameter int ID_BITS     = tet_pkg::ID_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [tet_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  wire logic [tet_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire tet_pkg::t_req                     i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output tet_pkg::t_rsp                          o_out_data
);

    localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int ENTRY_W = tet_pkg::KIND_W + ID_BITS + tet_pkg::TIME_W;

    tet_pkg::t_state r_state, n_state;
    tet_pkg::t_req   r_req,   n_req;
    tet_pkg::t_rsp   r_out,   n_out;
    logic            r_out_vld, n_out_vld;

    logic [tet_pkg::TIME_W-1:0] r_sight_to, r_hearing_to, r_attacked_to;

    logic [MAX_ENTRIES-1:0] r_valid, n_valid;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [CNT_W-1:0]       r_scan, n_scan;
    logic                   r_rd_pend, n_rd_pend;
    logic [IDX_W-1:0]       r_rd_idx, n_rd_idx;
    logic                   r_dup, n_dup;
    logic                   r_free_found, n_free_found;
    logic [IDX_W-1:0]       r_free_idx, n_free_idx;
    logic                   r_found, n_found;
    logic [CNT_W-1:0]       r_expired, n_expired;

    logic                   ram_we;
    logic [ENTRY_W-1:0]     ram_wdata;
    logic [ENTRY_W-1:0]     ram_rdata;
    logic [ID_BITS-1:0]     req_id;
    logic                   hit_vld;
    logic                   reg_ok;
    tet_pkg::t_cmp          cmp;

    assign req_id    = ID_BITS'(r_req.target_id);
    assign ram_wdata = {r_req.sense_kind, req_id, r_req.now};
    assign hit_vld   = r_rd_pend && r_valid[r_rd_idx];
    assign reg_ok    = (r_req.sense_kind != tet_pkg::KIND_UNUSED) && !r_dup;

    tet_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_free_idx),
        .i_wdata (ram_wdata),
        .i_raddr (r_scan[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    tet_cmp #(
        .ID_BITS (ID_BITS)
    ) u_cmp (
        .i_ent_kind    (ram_rdata[ENTRY_W-1 -: tet_pkg::KIND_W]),
        .i_ent_id      (ram_rdata[tet_pkg::TIME_W +: ID_BITS]),
        .i_ent_time    (ram_rdata[tet_pkg::TIME_W-1:0]),
        .i_req_kind    (r_req.sense_kind),
        .i_req_id      (req_id),
        .i_now         (r_req.now),
        .i_sight_to    (r_sight_to),
        .i_hearing_to  (r_hearing_to),
        .i_attacked_to (r_attacked_to),
        .o_cmp         (cmp)
    );

    // Timeout registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sight_to    <= tet_pkg::SIGHT_TIMEOUT_RST;
            r_hearing_to  <= tet_pkg::HEARING_TIMEOUT_RST;
            r_attacked_to <= tet_pkg::ATTACKED_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                tet_pkg::CFG_SIGHT:    r_sight_to    <= i_cfg_wdata;
                tet_pkg::CFG_HEARING:  r_hearing_to  <= i_cfg_wdata;
                tet_pkg::CFG_ATTACKED: r_attacked_to <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tet_pkg::S_IDLE;
            r_valid   <= '0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
            r_rd_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
            r_rd_pend <= n_rd_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_out        <= n_out;
        r_scan       <= n_scan;
        r_rd_idx     <= n_rd_idx;
        r_dup        <= n_dup;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_found      <= n_found;
        r_expired    <= n_expired;
    end

    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_out        = r_out;
        n_out_vld    = r_out_vld;
        n_valid      = r_valid;
        n_count      = r_count;
        n_scan       = r_scan;
        n_rd_pend    = 1'b0;
        n_rd_idx     = r_rd_idx;
        n_dup        = r_dup;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_found      = r_found;
        n_expired    = r_expired;
        ram_we       = 1'b0;
        o_in_ready   = 1'b0;

        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            tet_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_req        = i_in_data;
                    n_scan       = '0;
                    n_dup        = 1'b0;
                    n_free_found = 1'b0;
                    n_found      = 1'b0;
                    n_expired    = '0;
                    n_state      = tet_pkg::S_SCAN;
                end
            end

            tet_pkg::S_SCAN: begin
                // Issue the next RAM read; the entry read last cycle is compared now.
                if (r_scan != CNT_W'(MAX_ENTRIES)) begin
                    n_rd_pend = 1'b1;
                    n_rd_idx  = r_scan[IDX_W-1:0];
                    n_scan    = r_scan + 1'b1;
                end else begin
                    n_state = tet_pkg::S_DONE;
                end

                case (r_req.action)
                    tet_pkg::ACT_REGISTER: begin
                        // The highest free index wins since the walk is ascending.
                        if (r_rd_pend && !r_valid[r_rd_idx]) begin
                            n_free_found = 1'b1;
                            n_free_idx   = r_rd_idx;
                        end
                        if (hit_vld && cmp.key_eq) begin
                            n_dup = 1'b1;
                        end
                    end
                    tet_pkg::ACT_TICK: begin
                        if (hit_vld && cmp.aged) begin
                            n_valid[r_rd_idx] = 1'b0;
                            n_count           = r_count - 1'b1;
                            n_expired         = r_expired + 1'b1;
                        end
                    end
                    tet_pkg::ACT_REMOVE: begin
                        if (hit_vld && cmp.id_eq && !r_found) begin
                            n_valid[r_rd_idx] = 1'b0;
                            n_count           = r_count - 1'b1;
                            n_found           = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end

            tet_pkg::S_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    n_out_vld = 1'b1;
                    n_out     = '0;
                    case (r_req.action)
                        tet_pkg::ACT_REGISTER: begin
                            if (reg_ok && r_free_found) begin
                                ram_we                = 1'b1;
                                n_valid[r_free_idx]   = 1'b1;
                                n_count               = r_count + 1'b1;
                                n_out.success         = 1'b1;
                            end
                            n_out.table_full = reg_ok && !r_free_found;
                        end
                        tet_pkg::ACT_TICK: begin
                            n_out.success       = 1'b1;
                            n_out.expired_count = tet_pkg::COUNT_W'(r_expired);
                        end
                        tet_pkg::ACT_REMOVE: begin
                            n_out.success = r_found;
                        end
                        default: ;
                    endcase
                    n_out.occupied = tet_pkg::COUNT_W'(n_count);
                    n_state        = tet_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = tet_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
